/* rtl/core/pixel_coordinate_queue_macros.svh */
// Assertion macros used by the queue RTL.
`ifndef PIXEL_COORDINATE_QUEUE_MACROS_SVH
`define PIXEL_COORDINATE_QUEUE_MACROS_SVH

// Condition must hold in every cycle out of reset.
`define PCQ_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("pcq: invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define PCQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcq: next-cycle check failed");

`endif

/* rtl/core/pcq_pkg.sv */
// Types and constants of the pixel coordinate queue.
`default_nettype none
package pcq_pkg;

  localparam int unsigned FIELD_W        = 12;
  localparam int unsigned MAX_COORD_W    = 16;
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned COORD_BITS_DEF = 12;

  typedef enum logic [1:0] {
    OP_APPEND   = 2'd0,
    OP_TAKE     = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_CONTAINS = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                  operation;
    logic [FIELD_W-1:0]   coord_x;
    logic [FIELD_W-1:0]   coord_y;
  } pcq_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0]   head_x;
    logic [FIELD_W-1:0]   head_y;
    logic                 found;
    logic                 not_empty;
    status_e              status;
  } pcq_out_t;

  // Broadcast control seen by every cell.
  typedef struct packed {
    logic append;     // write key at the tail cell
    logic take;       // every cell loads its upstream neighbor
    logic remove;     // cells at or behind the first match load their neighbor
  } pcq_cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/pcq_cell.sv */
// One storage cell of the queue chain: holds an entry, matches, shifts.
`default_nettype none
module pcq_cell
  import pcq_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire pcq_cell_ctrl_t        ctrl_i,
  input  wire logic [COORD_BITS-1:0] key_x_i,
  input  wire logic [COORD_BITS-1:0] key_y_i,
  input  wire logic                  occupied_i,
  input  wire logic                  at_tail_i,
  input  wire logic [COORD_BITS-1:0] next_x_i,
  input  wire logic [COORD_BITS-1:0] next_y_i,
  input  wire logic                  seen_i,
  output logic                       seen_o,
  output logic [COORD_BITS-1:0]      x_o,
  output logic [COORD_BITS-1:0]      y_o
);

  logic [COORD_BITS-1:0] x_q, x_d, y_q, y_d;
  logic                  hit;
  logic                  load_next;

  always_comb begin
    hit       = occupied_i && (x_q == key_x_i) && (y_q == key_y_i);
    seen_o    = seen_i | hit;
    // seen_o is high here and everywhere downstream of the oldest match
    load_next = ctrl_i.take | (ctrl_i.remove & seen_o);
    x_d       = x_q;
    y_d       = y_q;
    if (ctrl_i.append && at_tail_i) begin
      x_d = key_x_i;
      y_d = key_y_i;
    end else if (load_next) begin
      x_d = next_x_i;
      y_d = next_y_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule
`default_nettype wire

/* rtl/core/pixel_coordinate_queue.sv */
// Top level of the pixel coordinate queue: cell chain, count and result register.
`default_nettype none
// Bounded FIFO of (x, y) pixel coordinates with search and delete by value.
// Each input item is one request: append at the tail, take the head, remove
// the oldest matching entry (younger entries close the gap, order kept), or
// test membership. Every item yields exactly one result item carrying the
// taken head (zero unless a take succeeded), a found flag (remove/contains),
// whether the queue holds anything after the request, and a status (ok,
// take on empty, append on full). Throughput is one item per clock while the
// output is not stalled; the request is applied to all cells at the same edge
// that loads the result register. The critical path is the match chain, which
// runs from cell 0 to the last cell to mark where the oldest match sits.
// Entries live in CAPACITY cells, oldest in cell 0; the fill count tells
// which cells hold data, so no clearing is needed after reset.
// in_stall_o is asserted only while a result waits and the output is stalled.
`include "pixel_coordinate_queue_macros.svh"
module pixel_coordinate_queue
  import pcq_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire pcq_in_t  in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output pcq_out_t      out_item_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]       count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  pcq_out_t               out_item_q, out_item_d;

  logic                   accept;
  logic                   is_full, is_empty;
  logic [MAX_COORD_W-1:0] key_x_ext, key_y_ext;
  logic [COORD_BITS-1:0]  key_x, key_y;
  logic [MAX_COORD_W-1:0] head_x_ext, head_y_ext;
  pcq_cell_ctrl_t         ctrl;
  logic                   found;

  logic [COORD_BITS-1:0]  cell_x [CAPACITY];
  logic [COORD_BITS-1:0]  cell_y [CAPACITY];
  logic                   seen   [CAPACITY+1];

  // Handshake: a new item is taken unless a result is stuck at the output.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);

  // Coordinates are held masked to COORD_BITS bits.
  assign key_x_ext = MAX_COORD_W'(in_item_i.coord_x);
  assign key_y_ext = MAX_COORD_W'(in_item_i.coord_y);
  assign key_x     = key_x_ext[COORD_BITS-1:0];
  assign key_y     = key_y_ext[COORD_BITS-1:0];

  // Request decode, gated so refused requests leave the cells untouched.
  always_comb begin
    ctrl = '0;
    if (accept) begin
      case (in_item_i.operation)
        OP_APPEND: ctrl.append = ~is_full;
        OP_TAKE:   ctrl.take   = ~is_empty;
        OP_REMOVE: ctrl.remove = 1'b1;
        default:   ctrl        = '0;
      endcase
    end
  end

  // The chain: match flag travels toward the tail, data moves toward the head.
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [COORD_BITS-1:0] nx, ny;
    if (i == CAPACITY - 1) begin : g_last
      assign nx = cell_x[i];
      assign ny = cell_y[i];
    end else begin : g_mid
      assign nx = cell_x[i+1];
      assign ny = cell_y[i+1];
    end

    pcq_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .key_x_i    (key_x),
      .key_y_i    (key_y),
      .occupied_i (CNT_W'(i) < count_q),
      .at_tail_i  (CNT_W'(i) == count_q),
      .next_x_i   (nx),
      .next_y_i   (ny),
      .seen_i     (seen[i]),
      .seen_o     (seen[i+1]),
      .x_o        (cell_x[i]),
      .y_o        (cell_y[i])
    );
  end

  assign found = seen[CAPACITY];

  assign head_x_ext = MAX_COORD_W'(cell_x[0]);
  assign head_y_ext = MAX_COORD_W'(cell_y[0]);

  // Fill count and result assembly.
  always_comb begin
    count_d    = count_q;
    out_item_d = out_item_q;
    if (accept) begin
      out_item_d        = '0;
      out_item_d.status = ST_OK;
      case (in_item_i.operation)
        OP_APPEND: begin
          if (is_full) begin
            out_item_d.status = ST_FULL;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_TAKE: begin
          if (is_empty) begin
            out_item_d.status = ST_EMPTY;
          end else begin
            out_item_d.head_x = head_x_ext[FIELD_W-1:0];
            out_item_d.head_y = head_y_ext[FIELD_W-1:0];
            count_d           = count_q - CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          out_item_d.found = found;
          if (found) begin
            count_d = count_q - CNT_W'(1);
          end
        end
        default: begin
          out_item_d.found = found;
        end
      endcase
      out_item_d.not_empty = (count_d != '0);
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Checks
  `PCQ_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY))
  `PCQ_ASSERT_ALWAYS(a_not_empty_tracks_count, !out_valid_q || (out_item_q.not_empty == (count_q != '0)))
  `PCQ_ASSERT_NEXT(a_full_refused, accept && (in_item_i.operation == OP_APPEND) && is_full, (out_item_q.status == ST_FULL) && (count_q == $past(count_q)))
  `PCQ_ASSERT_NEXT(a_take_shrinks, accept && (in_item_i.operation == OP_TAKE) && !is_empty, count_q == $past(count_q) - CNT_W'(1))

endmodule
`default_nettype wire

/* tb/sv/pixel_coordinate_queue_checker.sv */
// Checker for the pixel coordinate queue: tracks the queue contents and compares every result.
module pixel_coordinate_queue_checker
  import pcq_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  pcq_in_t     in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  pcq_out_t    out_item_i,
  output int unsigned error_count_o,
  output int unsigned pending_o,
  output int unsigned requests_o,
  output int unsigned results_o,
  output int unsigned full_refusals_o,
  output int unsigned empty_takes_o,
  output int unsigned match_hits_o
);

  // Shadow copy of the queue, oldest entry at index 0.
  logic [COORD_BITS-1:0] held_x [CAPACITY];
  logic [COORD_BITS-1:0] held_y [CAPACITY];
  int unsigned           held_count;

  pcq_out_t expected_results [$];

  // Index of the oldest entry equal to (x, y), or held_count if none.
  function automatic int unsigned oldest_match(input logic [COORD_BITS-1:0] x,
                                               input logic [COORD_BITS-1:0] y);
    for (int unsigned i = 0; i < held_count; i++) begin
      if (held_x[i] == x && held_y[i] == y) return i;
    end
    return held_count;
  endfunction

  // Close the gap at pos; younger entries move one place toward the head.
  function automatic void drop_entry(input int unsigned pos);
    for (int unsigned i = pos; i + 1 < held_count; i++) begin
      held_x[i] = held_x[i+1];
      held_y[i] = held_y[i+1];
    end
    held_count--;
  endfunction

  // Apply one request to the shadow queue and return the result it yields.
  function automatic pcq_out_t apply_request(input pcq_in_t req);
    pcq_out_t              res;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    int unsigned           pos;
    res    = '0;
    res.status = ST_OK;
    x      = COORD_BITS'(req.coord_x);
    y      = COORD_BITS'(req.coord_y);
    case (req.operation)
      OP_APPEND: begin
        if (held_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          held_x[held_count] = x;
          held_y[held_count] = y;
          held_count++;
        end
      end
      OP_TAKE: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.head_x = FIELD_W'(held_x[0]);
          res.head_y = FIELD_W'(held_y[0]);
          drop_entry(0);
        end
      end
      OP_REMOVE: begin
        pos = oldest_match(x, y);
        if (pos < held_count) begin
          res.found = 1'b1;
          drop_entry(pos);
        end
      end
      default: begin
        res.found = (oldest_match(x, y) < held_count);
      end
    endcase
    res.not_empty = (held_count != 0);
    return res;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      error_count_o++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pcq_out_t predicted;
    pcq_out_t oldest;
    if (!rst_ni) begin
      held_count      = 0;
      expected_results.delete();
      error_count_o   = 0;
      pending_o       = 0;
      requests_o      = 0;
      results_o       = 0;
      full_refusals_o = 0;
      empty_takes_o   = 0;
      match_hits_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predicted = apply_request(in_item_i);
        expected_results.push_back(predicted);
        requests_o++;
        if (predicted.status == ST_FULL) full_refusals_o++;
        if (predicted.status == ST_EMPTY) empty_takes_o++;
        if (predicted.found) match_hits_o++;
      end
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (expected_results.size() == 0) begin
          error_count_o++;
          $display("%0t: result with nothing expected: head=(%0d,%0d) found=%0b ne=%0b st=%0d",
                   $time, out_item_i.head_x, out_item_i.head_y, out_item_i.found,
                   out_item_i.not_empty, out_item_i.status);
        end else begin
          oldest = expected_results.pop_front();
          check_field("head_x", oldest.head_x, out_item_i.head_x);
          check_field("head_y", oldest.head_y, out_item_i.head_y);
          check_field("found", oldest.found, out_item_i.found);
          check_field("not_empty", oldest.not_empty, out_item_i.not_empty);
          check_field("status", oldest.status, out_item_i.status);
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

/* tb/sv/pixel_coordinate_queue_tb.sv */
// Testbench top of the pixel coordinate queue: clock, reset, stimulus and verdict.
module pixel_coordinate_queue_tb;
  import pcq_pkg::*;

  localparam int unsigned CAPACITY       = CAPACITY_DEF;
  localparam int unsigned COORD_BITS     = COORD_BITS_DEF;
  localparam int unsigned PHASES         = 14;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned POOL_SIZE      = 12;
  localparam int unsigned HOLD_OFF       = 200;   // long receiver hold-off, in cycles
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int unsigned TAIL_CYCLES    = 8;     // settle time after the last result

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  pcq_in_t  in_item_i   = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  pcq_out_t out_item_o;

  int unsigned error_count;
  int unsigned pending;
  int unsigned requests;
  int unsigned results;
  int unsigned full_refusals;
  int unsigned empty_takes;
  int unsigned match_hits;

  // Idle/stall percentages; the stimulus drops them to zero for a stretch.
  int unsigned sender_idle_pct = 31;
  int unsigned stall_pct       = 31;
  bit          hold_off_req    = 1'b0;

  // Small set of coordinates reused by requests so that remove and contains hit.
  logic [FIELD_W-1:0] pool_x [POOL_SIZE];
  logic [FIELD_W-1:0] pool_y [POOL_SIZE];

  int unsigned quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  pixel_coordinate_queue #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  pixel_coordinate_queue_checker #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_item_i       (in_item_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_item_i      (out_item_o),
    .error_count_o   (error_count),
    .pending_o       (pending),
    .requests_o      (requests),
    .results_o       (results),
    .full_refusals_o (full_refusals),
    .empty_takes_o   (empty_takes),
    .match_hits_o    (match_hits)
  );

  // Receiver: random stalls each cycle; on request, one long hold-off so that
  // the result register stays occupied and the block backs up its input.
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: any accepted item on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic pcq_in_t request_of(input op_e op, input int unsigned x,
                                         input int unsigned y);
    pcq_in_t req;
    req.operation = op;
    req.coord_x   = FIELD_W'(x);
    req.coord_y   = FIELD_W'(y);
    return req;
  endfunction

  // Random request; the mix of operations is set per phase. Coordinates come
  // mostly from the pool, the rest spans the whole field.
  function automatic pcq_in_t random_request(input int unsigned append_pct,
                                             input int unsigned take_pct);
    pcq_in_t     req;
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(99);
    if (roll < append_pct) begin
      req.operation = OP_APPEND;
    end else if (roll < append_pct + take_pct) begin
      req.operation = OP_TAKE;
    end else if ($urandom_range(1) == 1) begin
      req.operation = OP_REMOVE;
    end else begin
      req.operation = OP_CONTAINS;
    end
    if ($urandom_range(99) < 60) begin
      pick        = $urandom_range(POOL_SIZE - 1);
      req.coord_x = pool_x[pick];
      req.coord_y = pool_y[pick];
    end else begin
      req.coord_x = FIELD_W'($urandom);
      req.coord_y = FIELD_W'($urandom);
    end
    return req;
  endfunction

  // Offer one item, after a random idle gap, and hold it until accepted.
  // Stall is sampled at the falling edge, where it has settled.
  task automatic send_item(input pcq_in_t req);
    logic stalled;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned append_pct;
    int unsigned take_pct;

    pool_x[0] = '0;
    pool_y[0] = '0;
    pool_x[1] = '1;
    pool_y[1] = '1;
    pool_x[2] = '0;
    pool_y[2] = '1;
    for (int unsigned i = 3; i < POOL_SIZE; i++) begin
      pool_x[i] = FIELD_W'($urandom);
      pool_y[i] = FIELD_W'($urandom);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: requests on an empty queue, extremes of both coordinates,
    // duplicates (remove takes the oldest), an absent remove, removal from
    // the middle and the tail, head order, alternating bit patterns.
    send_item(request_of(OP_TAKE, 0, 0));
    send_item(request_of(OP_CONTAINS, 0, 0));
    send_item(request_of(OP_REMOVE, 0, 0));
    send_item(request_of(OP_APPEND, 0, 0));
    send_item(request_of(OP_APPEND, 4095, 4095));
    send_item(request_of(OP_APPEND, 0, 4095));
    send_item(request_of(OP_APPEND, 0, 0));
    send_item(request_of(OP_APPEND, 4095, 0));
    send_item(request_of(OP_CONTAINS, 4095, 4095));
    send_item(request_of(OP_CONTAINS, 1, 1));
    send_item(request_of(OP_REMOVE, 0, 0));
    send_item(request_of(OP_REMOVE, 2748, 291));
    send_item(request_of(OP_REMOVE, 0, 4095));
    send_item(request_of(OP_TAKE, 0, 0));
    send_item(request_of(OP_TAKE, 0, 0));
    send_item(request_of(OP_TAKE, 0, 0));
    send_item(request_of(OP_TAKE, 0, 0));
    send_item(request_of(OP_APPEND, 2730, 1365));
    send_item(request_of(OP_APPEND, 1365, 2730));
    send_item(request_of(OP_REMOVE, 1365, 2730));
    send_item(request_of(OP_TAKE, 4095, 4095));
    send_item(request_of(OP_TAKE, 4095, 4095));
    wait_drained();

    // Random phases cycle through fill, mixed, drain and search-heavy mixes.
    // Fill phases run the queue into its full limit, drain phases empty it.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0:       begin append_pct = 80; take_pct = 5;  end
        1:       begin append_pct = 35; take_pct = 25; end
        2:       begin append_pct = 10; take_pct = 60; end
        default: begin append_pct = 40; take_pct = 10; end
      endcase
      // One stretch at full rate on both sides.
      if (phase == 6) begin
        sender_idle_pct = 0;
        stall_pct       = 0;
      end else begin
        sender_idle_pct = 31;
        stall_pct       = 31;
      end
      // Long receiver hold-off while items keep coming: the block fills up.
      if (phase == 4 || phase == 9) hold_off_req = 1'b1;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_request(append_pct, take_pct));
      end
      if (phase % 3 == 2) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d requests and %0d results: %0d appends refused on full,",
             requests, results, full_refusals);
    $display("%0d takes on empty, %0d matches by remove or contains, %0d mismatches",
             empty_takes, match_hits, error_count);
    if (error_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/pcq_pkg.sv
rtl/core/pcq_cell.sv
rtl/core/pixel_coordinate_queue.sv
tb/sv/pixel_coordinate_queue_checker.sv
tb/sv/pixel_coordinate_queue_tb.sv
